// ===== src/jmsl_pkg.sv =====
// ----------------------------------------------------------------------------
// jmsl_pkg: shared types and constants of the JPEG MPF segment locator
// Transaction payloads, register indexes, status codes and marker codes.
// ----------------------------------------------------------------------------
package jmsl_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int SIZE_W      = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PRIMARY_SIZE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FILE_SIZE    = CFG_INDEX_W'(1);

  localparam logic [1:0] STATUS_FOUND     = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

  localparam logic [7:0] MARKER_PREFIX = 8'hFF;
  localparam logic [7:0] MARKER_SOI    = 8'hD8;
  localparam logic [7:0] MARKER_TEM    = 8'h01;
  localparam logic [7:0] MARKER_RST0   = 8'hD0;
  localparam logic [7:0] MARKER_RST7   = 8'hD7;
  localparam logic [7:0] MARKER_SOS    = 8'hDA;
  localparam logic [7:0] MARKER_EOI    = 8'hD9;
  localparam logic [7:0] MARKER_APP2   = 8'hE2;

  // "MPF" followed by a zero byte, element 0 first
  localparam logic [3:0][7:0] MPF_ID = {8'h00, 8'h46, 8'h50, 8'h4D};

  // first marker position, identifier offset inside a segment
  localparam int FIRST_MARKER_POS = 2;
  localparam int MARKER_LEN       = 2;
  localparam int ID_OFFSET        = 4;
  localparam int MIN_BOUND        = 6;
  localparam int MIN_SEG_LEN      = 2;
  localparam int MIN_MPF_SEG_LEN  = 6;
  // identifier to entries: endian and IFD header, three tags of 12, next-IFD word
  localparam int ENTRIES_OFFSET   = 4 + 4 + 2 + 3 * 12 + 4 + 4;
  localparam int ENTRY_BYTES      = 16;
  localparam int ENTRY_COUNT      = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SIZE_W-1:0] id_position;
    logic [SIZE_W-1:0] entries_position;
    logic [SIZE_W-1:0] second_offset;
  } result_item_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [SIZE_W-1:0]      data;
  } cfg_write_t;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_SEEK  = 6'b000010,
    PH_CODE  = 6'b000100,
    PH_LENHI = 6'b001000,
    PH_LENLO = 6'b010000,
    PH_MATCH = 6'b100000
  } phase_t;

endpackage

// ===== src/jmsl_stream_if.sv =====
// ----------------------------------------------------------------------------
// jmsl_stream_if: valid/ready channel
// Carries one payload per transaction from a source to a sink.
// ----------------------------------------------------------------------------
interface jmsl_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/jmsl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// jmsl_cfg_regs: size registers and search bound
// Holds primary and file size and forms the walk bound from them.
// ----------------------------------------------------------------------------
module jmsl_cfg_regs #(
  parameter int POSITION_BITS = 32,
  parameter int SW            = 34
) (
  input  logic                     clk,
  input  logic                     rst,
  jmsl_stream_if.sink              cfg,
  output logic [jmsl_pkg::SIZE_W-1:0] primary_size,
  output logic [jmsl_pkg::SIZE_W-1:0] file_size,
  output logic [SW-1:0]            bound
);

  localparam logic [SW-1:0] POS_MASK = {{(SW - POSITION_BITS){1'b0}}, {POSITION_BITS{1'b1}}};

  logic [SW-1:0] size_min;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      primary_size <= '0;
      file_size    <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.payload.reg_index)
        jmsl_pkg::REG_PRIMARY_SIZE: primary_size <= cfg.payload.data;
        jmsl_pkg::REG_FILE_SIZE:    file_size    <= cfg.payload.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    size_min = (file_size < primary_size) ? SW'(file_size) : SW'(primary_size);
    bound    = (POS_MASK < size_min) ? POS_MASK : size_min;
  end

endmodule

// ===== src/jmsl_walker.sv =====
// ----------------------------------------------------------------------------
// jmsl_walker: marker segment walk
// One byte per step: tracks position and segment, decides the search.
// ----------------------------------------------------------------------------
module jmsl_walker #(
  parameter int POSITION_BITS = 32,
  parameter int SW            = 34
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  jmsl_pkg::byte_item_t        item,
  input  logic [jmsl_pkg::SIZE_W-1:0] primary_size,
  input  logic [jmsl_pkg::SIZE_W-1:0] file_size,
  input  logic [SW-1:0]               bound,
  output logic                        hit,
  output jmsl_pkg::result_item_t      result
);

  localparam int PB = POSITION_BITS;

  jmsl_pkg::phase_t phase, phase_next, ph_e;
  logic [PB-1:0] byte_position, byte_position_next, p_e;
  logic [PB-1:0] segment_start, segment_start_next, seg_e;
  logic [PB-1:0] segment_end, segment_end_next;
  logic [7:0]    len_hi, len_hi_next;
  logic          is_app2, is_app2_next;
  logic [1:0]    id_count, id_count_next;

  logic [7:0]    b;
  logic [15:0]   seg_len;
  logic [SW-1:0] seg_w;
  logic [SW-1:0] end_w;
  logic [SW-1:0] adv_pos;
  logic          adv;
  logic          not_found;
  logic          found;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= jmsl_pkg::PH_IDLE;
      byte_position <= '0;
      segment_start <= PB'(jmsl_pkg::FIRST_MARKER_POS);
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      segment_start <= segment_start_next;
    end
  end

  always_ff @(posedge clk) begin
    segment_end <= segment_end_next;
    len_hi      <= len_hi_next;
    is_app2     <= is_app2_next;
    id_count    <= id_count_next;
  end

  always_comb begin
    b       = item.data_byte;
    ph_e    = item.first_byte ? jmsl_pkg::PH_SEEK : phase;
    p_e     = item.first_byte ? '0 : byte_position;
    seg_e   = item.first_byte ? PB'(jmsl_pkg::FIRST_MARKER_POS) : segment_start;
    seg_w   = SW'(seg_e);
    seg_len = {len_hi, b};
    end_w   = seg_w + SW'(jmsl_pkg::MARKER_LEN) + SW'(seg_len);

    phase_next         = phase;
    byte_position_next = byte_position;
    segment_start_next = segment_start;
    segment_end_next   = segment_end;
    len_hi_next        = len_hi;
    is_app2_next       = is_app2;
    id_count_next      = id_count;
    adv                = 1'b0;
    adv_pos            = end_w;
    not_found          = 1'b0;
    found              = 1'b0;

    if (step) begin
      if (item.first_byte) begin
        byte_position_next = '0;
        segment_start_next = seg_e;
        phase_next         = jmsl_pkg::PH_SEEK;
      end
      if (item.first_byte && (bound < SW'(jmsl_pkg::MIN_BOUND))) begin
        not_found = 1'b1;
      end else if (ph_e != jmsl_pkg::PH_IDLE) begin
        byte_position_next = p_e + PB'(1);
        unique case (ph_e)
          jmsl_pkg::PH_SEEK: begin
            if (p_e == seg_e) begin
              if (b != jmsl_pkg::MARKER_PREFIX) not_found = 1'b1;
              else phase_next = jmsl_pkg::PH_CODE;
            end
          end
          jmsl_pkg::PH_CODE: begin
            is_app2_next = (b == jmsl_pkg::MARKER_APP2);
            if (b == jmsl_pkg::MARKER_SOI || b == jmsl_pkg::MARKER_TEM ||
                (b >= jmsl_pkg::MARKER_RST0 && b <= jmsl_pkg::MARKER_RST7)) begin
              adv     = 1'b1;
              adv_pos = seg_w + SW'(jmsl_pkg::MARKER_LEN);
            end else if (b == jmsl_pkg::MARKER_SOS || b == jmsl_pkg::MARKER_EOI) begin
              not_found = 1'b1;
            end else begin
              phase_next = jmsl_pkg::PH_LENHI;
            end
          end
          jmsl_pkg::PH_LENHI: begin
            len_hi_next = b;
            phase_next  = jmsl_pkg::PH_LENLO;
          end
          jmsl_pkg::PH_LENLO: begin
            if (seg_len < 16'(jmsl_pkg::MIN_SEG_LEN) || end_w > bound) begin
              not_found = 1'b1;
            end else if (is_app2 && seg_len >= 16'(jmsl_pkg::MIN_MPF_SEG_LEN)) begin
              phase_next       = jmsl_pkg::PH_MATCH;
              segment_end_next = end_w[PB-1:0];
              id_count_next    = '0;
            end else begin
              adv     = 1'b1;
              adv_pos = end_w;
            end
          end
          jmsl_pkg::PH_MATCH: begin
            if (b != jmsl_pkg::MPF_ID[id_count]) begin
              adv     = 1'b1;
              adv_pos = SW'(segment_end);
            end else if (id_count == 2'd3) begin
              found = 1'b1;
            end else begin
              id_count_next = id_count + 2'd1;
            end
          end
          default: not_found = 1'b1;
        endcase
      end
    end

    if (adv) begin
      segment_start_next = adv_pos[PB-1:0];
      if (adv_pos + SW'(jmsl_pkg::ID_OFFSET) > bound) not_found = 1'b1;
      else phase_next = jmsl_pkg::PH_SEEK;
    end

    hit = found || not_found;
    if (hit) phase_next = jmsl_pkg::PH_IDLE;
  end

  logic [SW-1:0] id_w;
  logic [SW-1:0] ent_w;
  logic [SW-1:0] end_chk_w;
  logic [SW-1:0] off_base_w;

  always_comb begin
    id_w       = seg_w + SW'(jmsl_pkg::ID_OFFSET);
    ent_w      = seg_w + SW'(jmsl_pkg::ID_OFFSET + jmsl_pkg::ENTRIES_OFFSET);
    end_chk_w  = seg_w + SW'(jmsl_pkg::ID_OFFSET + jmsl_pkg::ENTRIES_OFFSET +
                             jmsl_pkg::ENTRY_COUNT * jmsl_pkg::ENTRY_BYTES);
    off_base_w = seg_w + SW'(2 * jmsl_pkg::ID_OFFSET);
    if (found) begin
      result.status           = (end_chk_w > SW'(file_size)) ? jmsl_pkg::STATUS_TRUNCATED
                                                             : jmsl_pkg::STATUS_FOUND;
      result.id_position      = id_w[jmsl_pkg::SIZE_W-1:0];
      result.entries_position = ent_w[jmsl_pkg::SIZE_W-1:0];
      result.second_offset    = primary_size - off_base_w[jmsl_pkg::SIZE_W-1:0];
    end else begin
      result.status           = jmsl_pkg::STATUS_NOT_FOUND;
      result.id_position      = '0;
      result.entries_position = '0;
      result.second_offset    = '0;
    end
  end

endmodule

// ===== src/jpeg_mpf_segment_locator_unit.sv =====
// ----------------------------------------------------------------------------
// jpeg_mpf_segment_locator_unit: locate the MPF APP2 segment of a JPEG file
// Walks marker segments of a byte stream and reports the MPF identifier.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in    : one file byte per transaction; first_byte marks byte zero and
//                restarts the search.
//   result_out : at most one result per file, on the byte that decides the
//                search (last byte of the MPF identifier on a match).
//   cfg        : writes primary_size (index 0) and file_size (index 1); always
//                ready, to be written only while no search is in flight.
// Throughput: one byte per cycle while no held result stalls byte_in.
// Result path: the deciding byte passes the input register, then the result
//   register, before its result is on result_out.
// Reset: sizes clear to zero and the walker idles until a first_byte arrives.
// Stall: when a result waits and result_out is not ready, one more byte is
//   held in the input register, then byte_in drops ready until the result
//   is taken.
// ----------------------------------------------------------------------------
module jpeg_mpf_segment_locator_unit #(
  parameter int POSITION_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  jmsl_stream_if.sink   byte_in,
  jmsl_stream_if.source result_out,
  jmsl_stream_if.sink   cfg
);

  localparam int SW = ((POSITION_BITS > jmsl_pkg::SIZE_W) ? POSITION_BITS
                                                          : jmsl_pkg::SIZE_W) + 2;

  logic                        in_valid;
  jmsl_pkg::byte_item_t        in_item;
  logic                        drain;
  logic                        step;
  logic                        hit;
  jmsl_pkg::result_item_t      result;
  logic                        res_valid;
  jmsl_pkg::result_item_t      res_item;
  logic [jmsl_pkg::SIZE_W-1:0] primary_size;
  logic [jmsl_pkg::SIZE_W-1:0] file_size;
  logic [SW-1:0]               bound;

  jmsl_cfg_regs #(
    .POSITION_BITS (POSITION_BITS),
    .SW            (SW)
  ) u_cfg_regs (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .primary_size (primary_size),
    .file_size    (file_size),
    .bound        (bound)
  );

  assign drain         = !res_valid || result_out.ready;
  assign step          = in_valid && drain;
  assign byte_in.ready = !in_valid || drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.ready) begin
      in_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.ready && byte_in.valid) begin
      in_item <= byte_in.payload;
    end
  end

  jmsl_walker #(
    .POSITION_BITS (POSITION_BITS),
    .SW            (SW)
  ) u_walker (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .item         (in_item),
    .primary_size (primary_size),
    .file_size    (file_size),
    .bound        (bound),
    .hit          (hit),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (drain) begin
      res_valid <= step && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      res_item <= result;
    end
  end

  assign result_out.valid   = res_valid;
  assign result_out.payload = res_item;

endmodule

// ===== verif/jpeg_mpf_segment_locator_unit_test.sv =====
// ---------------------------------------------------------------------------
// jpeg_mpf_segment_locator_unit_test: regression of the MPF segment locator
// Streams generated JPEG marker layouts and noise through the byte channel.
// Random idling and output back-pressure are applied until late in the random
// files, where both are switched off. Each search outcome is predicted and each
// result transaction is checked field by field, in order.
// ---------------------------------------------------------------------------
module jpeg_mpf_segment_locator_unit_test;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 160;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 40;
  localparam int ID_BYTES      = 4;
  localparam logic [63:0] POS_LIMIT   = 64'hFFFF_FFFF;
  localparam logic [7:0]  MARKER_APP0 = 8'hE0;

  logic clk = 1'b0;
  logic rst;

  jmsl_stream_if #(.payload_t(jmsl_pkg::byte_item_t))   byte_if ();
  jmsl_stream_if #(.payload_t(jmsl_pkg::result_item_t)) result_if ();
  jmsl_stream_if #(.payload_t(jmsl_pkg::cfg_write_t))   cfg_if ();

  jpeg_mpf_segment_locator_unit dut (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_if),
    .result_out(result_if),
    .cfg(cfg_if)
  );

  logic [63:0]            primary_size = '0;
  logic [63:0]            file_size = '0;
  jmsl_pkg::phase_t       walk_phase = jmsl_pkg::PH_IDLE;
  logic [63:0]            walk_pos = '0;
  logic [63:0]            seg_start = 64'(jmsl_pkg::FIRST_MARKER_POS);
  logic [7:0]             seg_code = '0;
  logic [15:0]            seg_len = '0;
  bit                     walk_done = 1'b1;
  jmsl_pkg::result_item_t search_reports[$];
  logic [7:0]             file_image[$];
  bit                     file_marks[$];
  int                     send_idle_pct = 32;
  int                     recv_stall_pct = 46;
  int                     fail_count = 0;
  int                     items_sent = 0;
  int                     hold_requests = 0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic logic [63:0] walk_bound();
    return (file_size < primary_size) ? file_size : primary_size;
  endfunction

  function automatic void conclude(input logic [1:0] verdict);
    jmsl_pkg::result_item_t r;
    logic [63:0]            id;
    logic [63:0]            ent;
    r = '0;
    r.status = verdict;
    if (verdict != jmsl_pkg::STATUS_NOT_FOUND) begin
      id  = seg_start + jmsl_pkg::ID_OFFSET;
      ent = id + jmsl_pkg::ENTRIES_OFFSET;
      r.id_position      = id[31:0];
      r.entries_position = ent[31:0];
      r.second_offset    = primary_size[31:0] - (id[31:0] + ID_BYTES);
      if (ent + jmsl_pkg::ENTRY_BYTES * jmsl_pkg::ENTRY_COUNT > file_size)
        r.status = jmsl_pkg::STATUS_TRUNCATED;
    end
    search_reports = {search_reports, r};
    walk_phase = jmsl_pkg::PH_IDLE;
    walk_done  = 1'b1;
  endfunction

  function automatic void next_marker(input logic [63:0] at);
    seg_start = at;
    if (at + jmsl_pkg::MARKER_LEN + 2 > walk_bound()) conclude(jmsl_pkg::STATUS_NOT_FOUND);
    else walk_phase = jmsl_pkg::PH_SEEK;
  endfunction

  function automatic void walk_byte(input jmsl_pkg::byte_item_t it);
    logic [63:0] p;
    logic [63:0] k;
    logic [7:0]  b;
    b = it.data_byte;
    if (it.first_byte) begin
      walk_pos   = '0;
      seg_start  = 64'(jmsl_pkg::FIRST_MARKER_POS);
      seg_code   = '0;
      seg_len    = '0;
      walk_done  = 1'b0;
      walk_phase = jmsl_pkg::PH_SEEK;
      if (jmsl_pkg::MIN_BOUND > walk_bound()) begin
        conclude(jmsl_pkg::STATUS_NOT_FOUND);
        return;
      end
    end
    if (walk_done || walk_phase == jmsl_pkg::PH_IDLE) begin
      walk_phase = jmsl_pkg::PH_IDLE;
      walk_done  = 1'b1;
      return;
    end
    p = walk_pos;
    walk_pos = (p + 1) & POS_LIMIT;
    case (walk_phase)
      jmsl_pkg::PH_SEEK: begin
        if (p == seg_start) begin
          if (b != jmsl_pkg::MARKER_PREFIX) conclude(jmsl_pkg::STATUS_NOT_FOUND);
          else walk_phase = jmsl_pkg::PH_CODE;
        end
      end
      jmsl_pkg::PH_CODE: begin
        seg_code = b;
        if (b == jmsl_pkg::MARKER_SOI || b == jmsl_pkg::MARKER_TEM ||
            (b >= jmsl_pkg::MARKER_RST0 && b <= jmsl_pkg::MARKER_RST7))
          next_marker(seg_start + jmsl_pkg::MARKER_LEN);
        else if (b == jmsl_pkg::MARKER_SOS || b == jmsl_pkg::MARKER_EOI)
          conclude(jmsl_pkg::STATUS_NOT_FOUND);
        else walk_phase = jmsl_pkg::PH_LENHI;
      end
      jmsl_pkg::PH_LENHI: begin
        seg_len    = {b, 8'h00};
        walk_phase = jmsl_pkg::PH_LENLO;
      end
      jmsl_pkg::PH_LENLO: begin
        seg_len[7:0] = b;
        if (seg_len < jmsl_pkg::MIN_SEG_LEN ||
            seg_start + jmsl_pkg::MARKER_LEN + seg_len > walk_bound())
          conclude(jmsl_pkg::STATUS_NOT_FOUND);
        else if (seg_code == jmsl_pkg::MARKER_APP2 && seg_len >= jmsl_pkg::MIN_MPF_SEG_LEN)
          walk_phase = jmsl_pkg::PH_MATCH;
        else
          next_marker(seg_start + jmsl_pkg::MARKER_LEN + seg_len);
      end
      jmsl_pkg::PH_MATCH: begin
        k = p - (seg_start + jmsl_pkg::ID_OFFSET);
        if (k > ID_BYTES - 1 || b != jmsl_pkg::MPF_ID[k[1:0]])
          next_marker(seg_start + jmsl_pkg::MARKER_LEN + seg_len);
        else if (k == ID_BYTES - 1)
          conclude(jmsl_pkg::STATUS_FOUND);
      end
      default: begin
        walk_phase = jmsl_pkg::PH_IDLE;
        walk_done  = 1'b1;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  function automatic void check_report(input jmsl_pkg::result_item_t got);
    jmsl_pkg::result_item_t want;
    if (search_reports.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: result expected none actual %h", $time, got);
      return;
    end
    want = search_reports.pop_front();
    check_field("status", want.status, got.status);
    check_field("id_position", want.id_position, got.id_position);
    check_field("entries_position", want.entries_position, got.entries_position);
    check_field("second_offset", want.second_offset, got.second_offset);
  endfunction

  function automatic void put(input logic [7:0] b);
    file_image = {file_image, b};
    file_marks = {file_marks, bit'(file_image.size() == 1)};
  endfunction

  // leading identifier bytes, optionally one wrong byte after them, then filler
  function automatic void put_segment(input logic [7:0] code, input int len,
                                      input int id_bytes, input bit spoil);
    put(jmsl_pkg::MARKER_PREFIX);
    put(code);
    put(8'(len >> 8));
    put(8'(len));
    for (int i = 0; i < len - 2 && i < 64; i++)
      put(i < id_bytes ? jmsl_pkg::MPF_ID[i] :
          (spoil && i == id_bytes) ? jmsl_pkg::MPF_ID[i] ^ 8'($urandom_range(1, 255)) :
          8'($urandom));
  endfunction

  function automatic void build_minimal_match();
    file_image.delete();
    file_marks.delete();
    put(jmsl_pkg::MARKER_PREFIX);
    put(jmsl_pkg::MARKER_SOI);
    put_segment(jmsl_pkg::MARKER_APP2, jmsl_pkg::MIN_MPF_SEG_LEN, ID_BYTES, 1'b0);
  endfunction

  function automatic void build_file();
    logic [7:0] lone;
    logic [7:0] code;
    file_image.delete();
    file_marks.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 24)) put(8'($urandom));
      foreach (file_marks[i]) if ($urandom_range(15) == 0) file_marks[i] = 1'b1;
      return;
    end
    put(($urandom_range(7) == 0) ? 8'($urandom) : jmsl_pkg::MARKER_PREFIX);
    put(($urandom_range(7) == 0) ? 8'($urandom) : jmsl_pkg::MARKER_SOI);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 4))
        0: begin
          case ($urandom_range(0, 2))
            0:       lone = jmsl_pkg::MARKER_SOI;
            1:       lone = jmsl_pkg::MARKER_TEM;
            default: lone = jmsl_pkg::MARKER_RST0 + 8'($urandom_range(0, 7));
          endcase
          put(jmsl_pkg::MARKER_PREFIX);
          put(lone);
        end
        1, 2: begin
          code = ($urandom_range(3) == 0) ? 8'($urandom) :
                 MARKER_APP0 | 8'($urandom_range(0, 15));
          put_segment(code, $urandom_range(2, 14), 0, 1'b0);
        end
        3: put_segment(jmsl_pkg::MARKER_APP2, $urandom_range(6, 12), $urandom_range(0, 3),
                       1'b1);
        default: put_segment(jmsl_pkg::MARKER_APP2, $urandom_range(2, 5), 0, 1'b0);
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: put_segment(jmsl_pkg::MARKER_APP2, $urandom_range(6, 40), ID_BYTES,
                                 1'b0);
      5: begin
        put(jmsl_pkg::MARKER_PREFIX);
        put(jmsl_pkg::MARKER_SOS);
      end
      6: begin
        put(jmsl_pkg::MARKER_PREFIX);
        put(jmsl_pkg::MARKER_EOI);
      end
      7: put(8'($urandom_range(0, jmsl_pkg::MARKER_PREFIX - 1)));
      8: put_segment(8'($urandom), ($urandom_range(1) == 0) ? $urandom_range(0, 1) :
                     $urandom_range(16'h0100, 16'hFFFF), 0, 1'b0);
      default: ;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] data, input bit first);
    jmsl_pkg::byte_item_t it;
    it.data_byte  = data;
    it.first_byte = first;
    while ($urandom_range(99) < send_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk);
    end
    byte_if.valid   <= 1'b1;
    byte_if.payload <= it;
    do @(posedge clk); while (!byte_if.ready);
    walk_byte(it);
    items_sent++;
  endtask

  // drop the rest of the file once the search has ended, mostly
  task automatic send_file();
    foreach (file_image[i]) begin
      send_byte(file_image[i], file_marks[i]);
      if (walk_done && $urandom_range(3) != 0) break;
    end
  endtask

  task automatic settle();
    byte_if.valid <= 1'b0;
    while (search_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // hold valid after the write; the caller drops it
  task automatic write_reg(input logic [jmsl_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] value);
    jmsl_pkg::cfg_write_t w;
    w.reg_index = idx;
    w.data      = value;
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= w;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == jmsl_pkg::REG_PRIMARY_SIZE) primary_size = 64'(value);
    else file_size = 64'(value);
  endtask

  task automatic set_sizes(input logic [31:0] primary, input logic [31:0] total);
    settle();
    write_reg(jmsl_pkg::REG_PRIMARY_SIZE, primary);
    write_reg(jmsl_pkg::REG_FILE_SIZE, total);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_files(input int count);
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      build_file();
      send_file();
    end
  endtask

  task automatic test_idle_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_start_bound();
    send_byte(jmsl_pkg::MARKER_PREFIX, 1'b1);
  endtask

  task automatic test_minimal_match();
    set_sizes(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    build_minimal_match();
    send_file();
  endtask

  task automatic test_truncated_entries();
    set_sizes(32'hFFFF_FFFF, 32'(jmsl_pkg::FIRST_MARKER_POS + jmsl_pkg::ID_OFFSET +
              jmsl_pkg::ENTRIES_OFFSET + jmsl_pkg::ENTRY_BYTES * jmsl_pkg::ENTRY_COUNT - 1));
    build_minimal_match();
    send_file();
  endtask

  task automatic test_random_files();
    send_idle_pct  = 32;
    recv_stall_pct = 46;
    set_sizes(32'd4000, 32'd4000);
    run_files(170);
    set_sizes(32'd150, 32'd5000);
    run_files(170);
    set_sizes(32'd5000, 32'd120);
    run_files(170);
    send_idle_pct  = 46;
    recv_stall_pct = 32;
    set_sizes(32'hFFFF_FFFF, 32'd300);
    run_files(170);
    set_sizes(32'd300, 32'hFFFF_FFFF);
    run_files(170);
    set_sizes(32'd60, 32'd60);
    run_files(170);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_sizes(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_files(170);
    set_sizes(32'(jmsl_pkg::MIN_BOUND), 32'(jmsl_pkg::MIN_BOUND));
    run_files(80);
    set_sizes(32'd0, 32'd0);
    run_files(60);
  endtask

  // every restart answers at once, so the block fills while results are held
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    set_sizes(32'(jmsl_pkg::MIN_BOUND - 1), 32'hFFFF_FFFF);
    hold_requests++;
    repeat (40) send_byte(8'($urandom), 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    byte_if.valid   = 1'b0;
    byte_if.payload = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.payload  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_idle_bytes();
    test_start_bound();
    test_minimal_match();
    test_truncated_entries();
    test_random_files();
    test_output_backpressure();
    settle();
    if (fail_count == 0) begin
      $display("jpeg_mpf_segment_locator_unit regression: pass");
    end else begin
      $display("jpeg_mpf_segment_locator_unit regression: fail");
    end
    $finish;
  end

  initial begin
    int hold_left;
    int holds_taken;
    hold_left   = 0;
    holds_taken = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_if.valid && result_if.ready) check_report(result_if.payload);
      if (holds_taken != hold_requests) begin
        holds_taken = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((byte_if.valid && byte_if.ready) || (result_if.valid && result_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("jpeg_mpf_segment_locator_unit regression: fail");
    $finish;
  end

endmodule
